### rtl/core/piecewise_linear_interpolator_unit_assert.svh
// Assertion macros for the piecewise-linear interpolator.
// Used by files that include it; expects i_clk and i_rst_n in scope.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pli_pkg.sv
// Package for the piecewise-linear interpolator: types, codes, helpers.
// No dependencies.
`timescale 1ns / 1ps

package pli_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // shared unit widths
    localparam int NUM_W  = 100;   // product / numerator
    localparam int DEN_W  = 50;    // divisor
    localparam int MUL_W  = 34;    // multiplier operand
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam int SUM_W  = 56;
    localparam int CAP_W  = 51;
    localparam int FRAC   = 16;
    localparam int FLAT_W = 48;

    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [NUM_W-1:0]         t_num;
    typedef logic [DEN_W-1:0]         t_den;
    typedef logic [STEP_W-1:0]        t_step;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [CAP_W-1:0]         t_cap;

    localparam t_cnt  MAX_CNT   = t_cnt'(MAX_POINTS);
    localparam t_step MUL_STEPS = t_step'(MUL_W);
    localparam t_step DIV_STEPS = t_step'(NUM_W);
    localparam t_cap  CAP_VAL   = {1'b1, {(CAP_W-1){1'b0}}};
    localparam t_sum  SAT_HI    = (t_sum'(1) <<< 47) - t_sum'(1);
    localparam t_sum  SAT_LO    = -(t_sum'(1) <<< 47);

    // operations
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_EVAL  = 2'd1;
    localparam logic [1:0] OP_INTEG = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    // extrapolation modes
    localparam logic [1:0] MODE_CLAMP  = 2'd0;
    localparam logic [1:0] MODE_EXTEND = 2'd1;
    localparam logic [1:0] MODE_UNDEF  = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNDEF   = 2'd1;
    localparam logic [1:0] ST_NOT_INC = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef enum logic {
        AR_MUL,
        AR_DIV
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
    } t_arith_cmd;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic [1:0]         extrapolation_mode;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
    } t_request;

    typedef struct packed {
        logic signed [47:0] result_value;
        logic [1:0]         status;
    } t_result;

    function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    function automatic logic [33:0] mag34(input logic signed [33:0] v);
        return v[33] ? 34'(-v) : 34'(v);
    endfunction

    function automatic t_cap cap50(input t_num q);
        return (q > t_num'(CAP_VAL)) ? CAP_VAL : q[CAP_W-1:0];
    endfunction

    function automatic logic signed [47:0] sat48(input t_sum v);
        t_sum r;
        r = v;
        if (v > SAT_HI) r = SAT_HI;
        if (v < SAT_LO) r = SAT_LO;
        return r[47:0];
    endfunction

endpackage

### rtl/core/pli_arith.sv
// Shared iterative arithmetic unit: shift-add multiply and restoring divide
// over one wide adder. Depends on pli_pkg.
`timescale 1ns / 1ps

module pli_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pli_pkg::t_arith_cmd i_cmd,
    input  pli_pkg::t_num       i_opa,
    input  pli_pkg::t_den       i_opb,
    output logic                o_done,
    output pli_pkg::t_num       o_res
);

    typedef logic [pli_pkg::NUM_W+1:0] t_add;

    logic                        r_run;
    logic                        r_done;
    pli_pkg::t_arith_op          r_op;
    pli_pkg::t_step              r_step;
    pli_pkg::t_num               r_acc;
    pli_pkg::t_num               r_mcand;
    logic [pli_pkg::MUL_W-1:0]   r_mplier;
    pli_pkg::t_den               r_rem;
    pli_pkg::t_den               r_div;

    logic [pli_pkg::DEN_W:0]     c_rem2;
    t_add                        c_a;
    t_add                        c_b;
    logic                        c_cin;
    t_add                        c_sum;
    logic                        c_ge;

    // one adder: accumulate for multiply, trial subtract for divide
    always_comb begin
        c_rem2 = {r_rem, r_acc[pli_pkg::NUM_W-1]};
        if (r_op == pli_pkg::AR_MUL) begin
            c_a   = t_add'(r_acc);
            c_b   = r_mplier[0] ? t_add'(r_mcand) : '0;
            c_cin = 1'b0;
        end else begin
            c_a   = t_add'(c_rem2);
            c_b   = ~t_add'(r_div);
            c_cin = 1'b1;
        end
        c_sum = c_a + c_b + t_add'(c_cin);
        c_ge  = !c_sum[pli_pkg::NUM_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_run <= 1'b1;
                r_op  <= i_cmd.op;
                if (i_cmd.op == pli_pkg::AR_MUL) begin
                    r_step   <= pli_pkg::MUL_STEPS;
                    r_acc    <= '0;
                    r_mcand  <= i_opa;
                    r_mplier <= i_opb[pli_pkg::MUL_W-1:0];
                end else begin
                    r_step <= pli_pkg::DIV_STEPS;
                    r_acc  <= i_opa;
                    r_rem  <= '0;
                    r_div  <= i_opb;
                end
            end else if (r_run) begin
                r_step <= r_step - pli_pkg::t_step'(1);
                if (r_step == pli_pkg::t_step'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
                if (r_op == pli_pkg::AR_MUL) begin
                    r_acc    <= c_sum[pli_pkg::NUM_W-1:0];
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                end else begin
                    r_rem <= c_ge ? c_sum[pli_pkg::DEN_W-1:0] : c_rem2[pli_pkg::DEN_W-1:0];
                    r_acc <= {r_acc[pli_pkg::NUM_W-2:0], c_ge};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

### rtl/core/piecewise_linear_interpolator_unit.sv
// Top level of the piecewise-linear interpolator: breakpoint table,
// sequencer and result register. Depends on pli_pkg, pli_arith and the assert header.
`timescale 1ns / 1ps
`include "piecewise_linear_interpolator_unit_assert.svh"

// Usage
//   Request channel: drive i_request and raise start; the request is taken
//   at a clock edge where start is high and busy is low. busy stays high
//   until the result is issued.
//   Result channel: o_result is valid for exactly one cycle with o_strobe.
//   The receiver cannot stall; busy drops in the strobe cycle, so a new
//   request may be taken while the result is shown.
//   Work per request (n = stored points, all scanned at most once):
//     add point            : strobe registered in the dispatch state
//     evaluate             : scan, then at most one 34-step multiply
//                            and one 100-step divide
//     integrate            : scan, plus four multiplies and one divide per
//                            segment overlapping the bounds and one multiply
//                            per end beyond the table
//   One request at a time; the rate is set by the shared multiply/divide
//   unit, which every product and quotient goes through in turn.
//   Reset empties the table (point count to zero) and idles the sequencer.
//   Table entries are plain flip-flops with no reset.

module piecewise_linear_interpolator_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pli_pkg::t_request i_request,
    output logic              o_strobe,
    output pli_pkg::t_result  o_result
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_FETCH,
        S_SCAN,
        S_EMUL,
        S_EDIV,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_SDIV,
        S_IFL,
        S_FLWL,
        S_IFR,
        S_FLWR,
        S_IFIN
    } t_state;

    t_state                 r_state;
    pli_pkg::t_request      r_req;
    pli_pkg::t_cnt          r_cnt;
    pli_pkg::t_cnt          r_k;
    logic signed [31:0]     r_last_x;

    // breakpoint table
    logic signed [31:0]     mem_x [pli_pkg::MAX_POINTS];
    logic signed [31:0]     mem_y [pli_pkg::MAX_POINTS];
    logic signed [31:0]     r_rdx;
    logic signed [31:0]     r_rdy;

    // scan registers: last point read, first point
    logic signed [31:0]     r_cx;
    logic signed [31:0]     r_cy;
    logic signed [31:0]     r_fx;
    logic signed [31:0]     r_fy;

    logic signed [31:0]     r_lo;
    logic signed [31:0]     r_hi;
    logic                   r_rev;

    // segment operands
    logic [31:0]            r_dx;
    logic signed [33:0]     r_dy;
    logic [31:0]            r_w;
    logic [32:0]            r_s;
    logic signed [31:0]     r_y0;
    logic signed [31:0]     r_by;
    logic                   r_neg;
    pli_pkg::t_num          r_ta;
    pli_pkg::t_sum          r_sum;

    pli_pkg::t_arith_cmd    r_ar_cmd;
    pli_pkg::t_num          r_ar_a;
    pli_pkg::t_den          r_ar_b;
    logic                   ar_done;
    pli_pkg::t_num          ar_res;

    logic                   r_strobe;
    pli_pkg::t_result       r_out;

    // combinational helpers
    logic                   c_not_inc;
    logic                   c_full;
    logic                   c_we;
    logic                   c_last;
    logic                   c_x_lt_cur;
    logic                   c_left;
    logic                   c_right;
    logic signed [31:0]     c_bx;
    logic signed [31:0]     c_byv;
    logic signed [33:0]     c_dx34;
    logic signed [33:0]     c_dy34;
    logic signed [33:0]     c_off34;
    logic [33:0]            c_dym;
    logic [33:0]            c_offm;
    logic signed [31:0]     c_sa;
    logic signed [31:0]     c_sb;
    logic signed [33:0]     c_w34;
    logic signed [33:0]     c_s34;
    logic [33:0]            c_y0m;
    logic [33:0]            c_ydm;
    logic signed [31:0]     c_le;
    logic signed [31:0]     c_rs;
    logic signed [33:0]     c_llen;
    logic signed [33:0]     c_rlen;
    logic [33:0]            c_fym;
    logic [33:0]            c_cym;
    logic signed [pli_pkg::NUM_W:0] c_ta_s;
    logic signed [pli_pkg::NUM_W:0] c_tb_s;
    logic signed [pli_pkg::NUM_W:0] c_p;
    pli_pkg::t_num          c_pmag;
    pli_pkg::t_cap          c_cap;
    pli_pkg::t_sum          c_capv;
    pli_pkg::t_sum          c_flatv;
    pli_pkg::t_sum          c_evalv;
    pli_pkg::t_sum          c_intv;

    always_comb begin
        c_not_inc  = (r_cnt != '0) && (r_req.x_value <= r_last_x);
        c_full     = (r_cnt == pli_pkg::MAX_CNT);
        c_we       = (r_state == S_DISP) && (r_req.operation == pli_pkg::OP_ADD)
                     && !c_not_inc && !c_full;
        c_last     = (r_k == r_cnt - pli_pkg::t_cnt'(1));
        c_x_lt_cur = (r_req.x_value < r_rdx);
        c_left     = (r_k == pli_pkg::t_cnt'(1)) && (r_req.x_value < r_cx);
        c_right    = !c_x_lt_cur;
        // right extrapolation runs from the last point, else from the segment start
        c_bx       = (c_right && !c_left) ? r_rdx : r_cx;
        c_byv      = (c_right && !c_left) ? r_rdy : r_cy;
        c_dx34     = pli_pkg::sx34(r_rdx) - pli_pkg::sx34(r_cx);
        c_dy34     = pli_pkg::sx34(r_rdy) - pli_pkg::sx34(r_cy);
        c_off34    = pli_pkg::sx34(r_req.x_value) - pli_pkg::sx34(c_bx);
        c_dym      = pli_pkg::mag34(c_dy34);
        c_offm     = pli_pkg::mag34(c_off34);

        // clip of the integration interval to the segment just read
        c_sa       = (r_lo > r_cx) ? r_lo : r_cx;
        c_sb       = (r_hi < r_rdx) ? r_hi : r_rdx;
        c_w34      = pli_pkg::sx34(c_sb) - pli_pkg::sx34(c_sa);
        c_s34      = (pli_pkg::sx34(c_sa) - pli_pkg::sx34(r_cx))
                     + (pli_pkg::sx34(c_sb) - pli_pkg::sx34(r_cx));
        c_y0m      = pli_pkg::mag34(pli_pkg::sx34(r_y0));
        c_ydm      = pli_pkg::mag34(r_dy);

        // flat parts beyond the table
        c_le       = (r_hi < r_fx) ? r_hi : r_fx;
        c_rs       = (r_lo > r_cx) ? r_lo : r_cx;
        c_llen     = pli_pkg::sx34(c_le) - pli_pkg::sx34(r_lo);
        c_rlen     = pli_pkg::sx34(r_hi) - pli_pkg::sx34(c_rs);
        c_fym      = pli_pkg::mag34(pli_pkg::sx34(r_fy));
        c_cym      = pli_pkg::mag34(pli_pkg::sx34(r_cy));

        // signed trapezoid numerator
        c_ta_s     = r_y0[31] ? -$signed({1'b0, r_ta}) : $signed({1'b0, r_ta});
        c_tb_s     = r_dy[33] ? -$signed({1'b0, ar_res}) : $signed({1'b0, ar_res});
        c_p        = c_ta_s + c_tb_s;
        c_pmag     = c_p[pli_pkg::NUM_W] ? pli_pkg::t_num'(-c_p) : pli_pkg::t_num'(c_p);

        c_cap      = pli_pkg::cap50(ar_res);
        c_capv     = r_neg ? -pli_pkg::t_sum'(c_cap) : pli_pkg::t_sum'(c_cap);
        c_flatv    = r_neg ? -pli_pkg::t_sum'(ar_res[pli_pkg::FRAC +: pli_pkg::FLAT_W])
                           : pli_pkg::t_sum'(ar_res[pli_pkg::FRAC +: pli_pkg::FLAT_W]);
        c_evalv    = pli_pkg::t_sum'(r_by) + c_capv;
        c_intv     = r_rev ? -r_sum : r_sum;
    end

    // table storage, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            mem_x[r_cnt[pli_pkg::IDX_W-1:0]] <= r_req.x_value;
            mem_y[r_cnt[pli_pkg::IDX_W-1:0]] <= r_req.y_value;
        end
        r_rdx <= mem_x[r_k[pli_pkg::IDX_W-1:0]];
        r_rdy <= mem_y[r_k[pli_pkg::IDX_W-1:0]];
    end

    pli_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_ar_cmd),
        .i_opa   (r_ar_a),
        .i_opb   (r_ar_b),
        .o_done  (ar_done),
        .o_res   (ar_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_strobe       <= 1'b0;
            r_ar_cmd.start <= 1'b0;
            r_ar_cmd.op    <= pli_pkg::AR_MUL;
        end else begin
            r_strobe       <= 1'b0;
            r_ar_cmd.start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req   <= i_request;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_k   <= '0;
                    r_sum <= '0;
                    r_rev <= (r_req.lower_bound > r_req.upper_bound);
                    r_lo  <= (r_req.lower_bound > r_req.upper_bound) ?
                             r_req.upper_bound : r_req.lower_bound;
                    r_hi  <= (r_req.lower_bound > r_req.upper_bound) ?
                             r_req.lower_bound : r_req.upper_bound;
                    r_out.result_value <= '0;
                    case (r_req.operation) inside
                        pli_pkg::OP_ADD: begin
                            r_strobe <= 1'b1;
                            r_state  <= S_IDLE;
                            if (c_not_inc) begin
                                r_out.status <= pli_pkg::ST_NOT_INC;
                            end else if (c_full) begin
                                r_out.status <= pli_pkg::ST_FULL;
                            end else begin
                                r_out.status <= pli_pkg::ST_OK;
                                r_cnt        <= r_cnt + pli_pkg::t_cnt'(1);
                                r_last_x     <= r_req.x_value;
                            end
                        end
                        pli_pkg::OP_EVAL, pli_pkg::OP_INTEG: begin
                            if (r_cnt < pli_pkg::t_cnt'(2)) begin
                                r_out.status <= pli_pkg::ST_UNDEF;
                                r_strobe     <= 1'b1;
                                r_state      <= S_IDLE;
                            end else begin
                                r_state <= S_FETCH;
                            end
                        end
                        default: begin
                            r_out.status <= pli_pkg::ST_UNDEF;
                            r_strobe     <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                    endcase
                end
                S_FETCH: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_cx <= r_rdx;
                    r_cy <= r_rdy;
                    if (r_k == '0) begin
                        r_fx    <= r_rdx;
                        r_fy    <= r_rdy;
                        r_k     <= r_k + pli_pkg::t_cnt'(1);
                        r_state <= S_FETCH;
                    end else if (r_req.operation == pli_pkg::OP_EVAL) begin
                        if (!c_x_lt_cur && !c_last) begin
                            r_k     <= r_k + pli_pkg::t_cnt'(1);
                            r_state <= S_FETCH;
                        end else begin
                            r_dx   <= c_dx34[31:0];
                            r_by   <= c_byv;
                            r_neg  <= c_dy34[33] ^ c_off34[33];
                            r_ar_a <= pli_pkg::t_num'(c_dym);
                            r_ar_b <= pli_pkg::t_den'(c_offm);
                            r_ar_cmd.op <= pli_pkg::AR_MUL;
                            if (c_left || c_right) begin
                                // outside the table, or exactly on the last point
                                if ((c_right && !c_left && r_req.x_value == r_rdx)
                                    || r_req.extrapolation_mode == pli_pkg::MODE_CLAMP) begin
                                    r_out.result_value <= 48'(c_byv);
                                    r_out.status       <= pli_pkg::ST_OK;
                                    r_strobe           <= 1'b1;
                                    r_state            <= S_IDLE;
                                end else if (r_req.extrapolation_mode
                                             == pli_pkg::MODE_EXTEND) begin
                                    r_ar_cmd.start <= 1'b1;
                                    r_state        <= S_EMUL;
                                end else begin
                                    r_out.status <= pli_pkg::ST_UNDEF;
                                    r_strobe     <= 1'b1;
                                    r_state      <= S_IDLE;
                                end
                            end else begin
                                r_ar_cmd.start <= 1'b1;
                                r_state        <= S_EMUL;
                            end
                        end
                    end else begin
                        if (c_sa < c_sb) begin
                            r_dx   <= c_dx34[31:0];
                            r_dy   <= c_dy34;
                            r_w    <= c_w34[31:0];
                            r_s    <= c_s34[32:0];
                            r_y0   <= r_cy;
                            r_ar_a <= pli_pkg::t_num'(c_dx34[31:0]);
                            r_ar_b <= pli_pkg::t_den'(c_w34[31:0]);
                            r_ar_cmd.op    <= pli_pkg::AR_MUL;
                            r_ar_cmd.start <= 1'b1;
                            r_state        <= S_M1;
                        end else if (c_last) begin
                            r_state <= S_IFL;
                        end else begin
                            r_k     <= r_k + pli_pkg::t_cnt'(1);
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_EMUL: begin
                    if (ar_done) begin
                        r_ar_a         <= ar_res;
                        r_ar_b         <= pli_pkg::t_den'(r_dx);
                        r_ar_cmd.op    <= pli_pkg::AR_DIV;
                        r_ar_cmd.start <= 1'b1;
                        r_state        <= S_EDIV;
                    end
                end
                S_EDIV: begin
                    if (ar_done) begin
                        r_out.result_value <= pli_pkg::sat48(c_evalv);
                        r_out.status       <= pli_pkg::ST_OK;
                        r_strobe           <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                // trapezoid: (dx*w)*2|y0| and (w*s)*|dy|, then one divide
                S_M1: begin
                    if (ar_done) begin
                        r_ar_a         <= ar_res;
                        r_ar_b         <= pli_pkg::t_den'({c_y0m[32:0], 1'b0});
                        r_ar_cmd.start <= 1'b1;
                        r_state        <= S_M2;
                    end
                end
                S_M2: begin
                    if (ar_done) begin
                        r_ta           <= ar_res;
                        r_ar_a         <= pli_pkg::t_num'(r_w);
                        r_ar_b         <= pli_pkg::t_den'(r_s);
                        r_ar_cmd.start <= 1'b1;
                        r_state        <= S_M3;
                    end
                end
                S_M3: begin
                    if (ar_done) begin
                        r_ar_a         <= ar_res;
                        r_ar_b         <= pli_pkg::t_den'(c_ydm);
                        r_ar_cmd.start <= 1'b1;
                        r_state        <= S_M4;
                    end
                end
                S_M4: begin
                    if (ar_done) begin
                        r_neg          <= c_p[pli_pkg::NUM_W];
                        r_ar_a         <= c_pmag;
                        r_ar_b         <= pli_pkg::t_den'({r_dx, 17'b0});
                        r_ar_cmd.op    <= pli_pkg::AR_DIV;
                        r_ar_cmd.start <= 1'b1;
                        r_state        <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    if (ar_done) begin
                        r_sum <= r_sum + c_capv;
                        if (c_last) begin
                            r_state <= S_IFL;
                        end else begin
                            r_k     <= r_k + pli_pkg::t_cnt'(1);
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_IFL: begin
                    if (r_lo < r_fx) begin
                        r_neg          <= r_fy[31];
                        r_ar_a         <= pli_pkg::t_num'(c_fym);
                        r_ar_b         <= pli_pkg::t_den'(c_llen[32:0]);
                        r_ar_cmd.op    <= pli_pkg::AR_MUL;
                        r_ar_cmd.start <= 1'b1;
                        r_state        <= S_FLWL;
                    end else begin
                        r_state <= S_IFR;
                    end
                end
                S_FLWL: begin
                    if (ar_done) begin
                        r_sum   <= r_sum + c_flatv;
                        r_state <= S_IFR;
                    end
                end
                S_IFR: begin
                    if (r_hi > r_cx) begin
                        r_neg          <= r_cy[31];
                        r_ar_a         <= pli_pkg::t_num'(c_cym);
                        r_ar_b         <= pli_pkg::t_den'(c_rlen[32:0]);
                        r_ar_cmd.op    <= pli_pkg::AR_MUL;
                        r_ar_cmd.start <= 1'b1;
                        r_state        <= S_FLWR;
                    end else begin
                        r_state <= S_IFIN;
                    end
                end
                S_FLWR: begin
                    if (ar_done) begin
                        r_sum   <= r_sum + c_flatv;
                        r_state <= S_IFIN;
                    end
                end
                S_IFIN: begin
                    r_out.result_value <= pli_pkg::sat48(c_intv);
                    r_out.status       <= pli_pkg::ST_OK;
                    r_strobe           <= 1'b1;
                    r_state            <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    `PLI_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request taken but block not busy")
    `PLI_ASSERT_SAME(a_strobe_idle, o_strobe, !busy, "result issued while busy")
    `PLI_ASSERT_SAME(a_err_zero, o_strobe && (o_result.status != pli_pkg::ST_OK), o_result.result_value == '0, "nonzero value with error status")
    `PLI_ASSERT_SAME(a_cnt_range, 1'b1, r_cnt <= pli_pkg::MAX_CNT, "point count beyond table size")

endmodule
